### rtl/core/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZSS decompressor: history geometry and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = 12;
  localparam int CFG_W      = 24;
  localparam int LEN_W      = 5;

  // controller to datapath, one cycle each
  typedef struct packed {
    logic               clr_count;  // restart the produced-byte count
    logic               emit;       // write one byte to history and the output word
    logic               emit_mem;   // emitted byte comes from the history read
    logic               run_last;   // emitted byte closes the input word's run
    logic               rd_start;   // first history read of a copy
    logic               rd_next;    // following history read of a copy
    logic [HIST_AW-1:0] field;      // token offset field
    logic [7:0]         lit_byte;   // literal byte
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic len_zero;    // configured length is zero
    logic cnt_at_end;  // produced count has reached the length
    logic next_done;   // one more byte reaches the length
    logic slot_free;   // output register can take a byte this cycle
  } sts_t;

endpackage

### rtl/core/lzss_decompress_4k_window.sv
// ----------------------------------------------------------------------------
// lzss_decompress_4k_window
// LZSS decompressor over a 4096-byte history. Takes one compressed byte per
// input word and emits the decompressed bytes, one per output word. A flag
// word, a literal and the low token byte take one input word each; the high
// token byte starts a copy of length field + 3 bytes (3 to 18) out of the
// history, one registered read per byte, with the byte written in the same
// cycle forwarded for overlapping runs. Output backpressure stalls the copy.
// History entries never written since reset read as zero, tracked by the
// write pointer and a wrap mark, so no clearing pass is needed and the block
// is ready right after reset. out_length is to be written on the cfg port
// only while the block is idle; the block does not enforce it. tlast marks
// the last byte caused by an input word, tuser the one completing out_length.
// ----------------------------------------------------------------------------
module lzss_decompress_4k_window #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] stream_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // run_last
  output logic [0:0]  out_tuser,  // [0] stream_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // out_length
);
  import lzd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // config register is always writable
  assign cfg_ready = 1'b1;

  lzd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser[0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_done   (out_tuser[0])
  );

endmodule

### rtl/core/lzd_ctrl.sv
// ----------------------------------------------------------------------------
// lzd_ctrl
// Decode controller: walks flag bits, collects token bytes and sequences
// the byte copies out of the history, one emitted byte per cycle while the output register has room.
// ----------------------------------------------------------------------------
module lzd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_byte,
  input  logic          in_start,
  input  lzd_pkg::sts_t sts,
  output lzd_pkg::cmd_t cmd
);
  import lzd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_DATA,
    PH_HIGH
  } phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  phase_t             ph;
  logic [7:0]         flag_bits_r, flag_bits_nxt;
  logic [2:0]         flag_idx_r, flag_idx_nxt;
  logic [2:0]         flag_idx_inc;
  logic [7:0]         token_low_r, token_low_nxt;
  logic               finished_r, finished_nxt;
  logic [LEN_W-1:0]   emit_cnt_r, emit_cnt_nxt;
  logic [LEN_W-1:0]   len_m1_r, len_m1_nxt;
  logic               stop;

  assign in_tready    = (state_r == ST_IDLE) && sts.slot_free;
  assign flag_idx_inc = flag_idx_r + 3'd1;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    flag_bits_nxt = flag_bits_r;
    flag_idx_nxt  = flag_idx_r;
    token_low_nxt = token_low_r;
    finished_nxt  = finished_r;
    emit_cnt_nxt  = emit_cnt_r;
    len_m1_nxt    = len_m1_r;
    ph            = in_start ? PH_FLAG : phase_r;
    stop          = 1'b0;
    cmd           = '0;
    cmd.lit_byte  = in_byte;
    cmd.field     = {in_byte[3:0], token_low_r};

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          // a new stream restarts decoding at a flag word
          if (in_start) begin
            cmd.clr_count = 1'b1;
            phase_nxt     = PH_FLAG;
            flag_idx_nxt  = '0;
            finished_nxt  = 1'b0;
          end
          if ((!in_start && finished_r) ||
              (in_start ? sts.len_zero : sts.cnt_at_end)) begin
            // drop words past the end of the stream
            finished_nxt = 1'b1;
          end else begin
            case (ph)
              PH_DATA: begin
                if (flag_bits_r[flag_idx_r]) begin
                  // literal goes straight out
                  cmd.emit     = 1'b1;
                  cmd.run_last = 1'b1;
                  if (sts.next_done) begin
                    finished_nxt = 1'b1;
                  end
                  flag_idx_nxt = flag_idx_inc;
                  phase_nxt    = (flag_idx_inc == 3'd0) ? PH_FLAG : PH_DATA;
                end else begin
                  token_low_nxt = in_byte;
                  phase_nxt     = PH_HIGH;
                end
              end
              PH_HIGH: begin
                // issue the first history read and enter the copy
                cmd.rd_start = 1'b1;
                len_m1_nxt   = {1'b0, in_byte[7:4]} + LEN_W'(2);
                emit_cnt_nxt = '0;
                state_nxt    = ST_COPY;
              end
              default: begin
                flag_bits_nxt = in_byte;
                flag_idx_nxt  = '0;
                phase_nxt     = PH_DATA;
              end
            endcase
          end
        end
      end
      ST_COPY: begin
        // emit one copied byte per free output slot, read the next one
        if (sts.slot_free) begin
          stop         = (emit_cnt_r == len_m1_r) || sts.next_done;
          cmd.emit     = 1'b1;
          cmd.emit_mem = 1'b1;
          cmd.run_last = stop;
          emit_cnt_nxt = emit_cnt_r + LEN_W'(1);
          if (stop) begin
            state_nxt    = ST_IDLE;
            if (sts.next_done) begin
              finished_nxt = 1'b1;
            end
            flag_idx_nxt = flag_idx_inc;
            phase_nxt    = (flag_idx_inc == 3'd0) ? PH_FLAG : PH_DATA;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state and decode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FLAG;
      flag_bits_r <= '0;
      flag_idx_r  <= '0;
      token_low_r <= '0;
      finished_r  <= 1'b0;
      emit_cnt_r  <= '0;
      len_m1_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_idx_r  <= flag_idx_nxt;
      token_low_r <= token_low_nxt;
      finished_r  <= finished_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      len_m1_r    <= len_m1_nxt;
    end
  end

endmodule

### rtl/core/lzd_datapath.sv
// ----------------------------------------------------------------------------
// lzd_datapath
// History memory with registered read and write forwarding, write pointer
// and fill mark, produced-byte count, length register and output register.
// ----------------------------------------------------------------------------
module lzd_datapath #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [lzd_pkg::CFG_W-1:0] cfg_data,
  input  lzd_pkg::cmd_t          cmd,
  output lzd_pkg::sts_t          sts,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   out_done
);
  import lzd_pkg::*;

  logic [CFG_W-1:0]       len_r;
  logic [COUNT_WIDTH-1:0] len_eff;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [HIST_AW-1:0]     wpos_r;
  logic                   full_r;
  logic [HIST_AW-1:0]     src_r;
  logic [HIST_AW-1:0]     rd_addr;
  logic                   rd_en;
  logic [7:0]             hist_mem [HIST_DEPTH];
  logic [7:0]             mem_q_r;
  logic                   fwd_r;
  logic [7:0]             fwd_byte_r;
  logic                   zero_r;
  logic [7:0]             rd_byte;
  logic [7:0]             emit_byte;
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;
  logic                   out_done_r;

  // fit the configured length to the counter width
  if (COUNT_WIDTH > CFG_W) begin : g_len_ext
    assign len_eff = {{(COUNT_WIDTH-CFG_W){1'b0}}, len_r};
  end else if (COUNT_WIDTH == CFG_W) begin : g_len_eq
    assign len_eff = len_r;
  end else begin : g_len_cut
    assign len_eff = len_r[COUNT_WIDTH-1:0];
  end

  assign cnt_inc = cnt_r + COUNT_WIDTH'(1);

  assign sts.len_zero   = (len_eff == '0);
  assign sts.cnt_at_end = (cnt_r >= len_eff);
  assign sts.next_done  = (cnt_inc >= len_eff);
  assign sts.slot_free  = !out_valid_r || out_tready;

  // history read address: token start or running source pointer
  assign rd_en   = cmd.rd_start || cmd.rd_next;
  assign rd_addr = cmd.rd_start ? (wpos_r + cmd.field) : src_r;

  // never-written entries read as zero, same-cycle writes are forwarded
  assign rd_byte   = fwd_r ? fwd_byte_r : (zero_r ? 8'h00 : mem_q_r);
  assign emit_byte = cmd.emit_mem ? rd_byte : cmd.lit_byte;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      cnt_r       <= '0;
      wpos_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      if (cmd.clr_count) begin
        cnt_r <= '0;
      end else if (cmd.emit) begin
        cnt_r <= cnt_inc;
      end
      if (cmd.emit) begin
        wpos_r      <= wpos_r + HIST_AW'(1);
        full_r      <= full_r || (wpos_r == '1);
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hist_mem[wpos_r] <= emit_byte;
    end
    if (rd_en) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  // read side flags, source pointer and output word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      src_r      <= rd_addr + HIST_AW'(1);
      fwd_r      <= cmd.emit && (rd_addr == wpos_r);
      fwd_byte_r <= emit_byte;
      zero_r     <= !(full_r || (rd_addr < wpos_r));
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.run_last;
      out_done_r <= sts.next_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_done   = out_done_r;

endmodule

### rtl/core/lzd_checker.sv
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks of the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output word changed");

  // the byte that completes the stream also ends its run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("stream done without run end");

  // no input is taken while a result is blocked
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input accepted while output stalled");

endmodule

bind lzss_decompress_4k_window lzd_checker u_lzd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the LZSS decompressor. Sends compressed byte streams on the
// input stream and predicts every decompressed byte from its own copy of the
// history window and the decode state. Each output word is checked field by
// field against the oldest prediction. Directed streams exercise reset
// history, overlapping copies, truncated runs and ignored bytes. A held-off
// receiver fills the block, and random streams vary the configured length,
// restarts and handshake timing.
// ----------------------------------------------------------------------------
module tb;
  import lzd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEM_TARGET    = 480;
  localparam int MAX_REPORTS    = 100;

  typedef enum logic [1:0] {DEC_FLAG, DEC_DATA, DEC_HIGH} dec_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_word_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic [0:0]        in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic [0:0]        out_tuser;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data   = '0;

  // decoder state mirrored by the testbench
  logic [7:0]         hist [HIST_DEPTH];
  logic [HIST_AW-1:0] wr_pos;
  logic [7:0]         flag_bits;
  logic [2:0]         flag_idx;
  dec_phase_t         dec_phase;
  logic [7:0]         tok_low;
  logic [CFG_W-1:0]   dec_count;
  logic               dec_finished;
  logic [CFG_W-1:0]   dec_length;

  out_word_t exp_bytes [$];
  out_word_t run_bytes [$];

  int       n_errors   = 0;
  int       n_taken    = 0;
  int       stall_cnt  = 0;
  bit       tx_idle_on = 1'b0;
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_ALWAYS;
  int       hold_req   = 0;
  int       hold_ack   = 0;
  int       hold_left  = 0;
  logic [10:0] rx_pat  = 11'b101_1001_1101;

  lzss_decompress_4k_window i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // write one decoded byte to the history and queue its prediction
  task automatic emit_byte(input logic [7:0] v);
    out_word_t w;
    hist[wr_pos] = v;
    wr_pos       = wr_pos + 1'b1;
    dec_count    = dec_count + 1'b1;
    w.data       = v;
    w.last       = 1'b0;
    w.done       = (dec_count >= dec_length);
    if (w.done) dec_finished = 1'b1;
    run_bytes.push_back(w);
  endtask

  task automatic advance_flag();
    flag_idx  = flag_idx + 1'b1;
    dec_phase = (flag_idx == 3'd0) ? DEC_FLAG : DEC_DATA;
  endtask

  // decode one accepted compressed byte into expected output words
  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [HIST_AW-1:0] field;
    logic [HIST_AW-1:0] src;
    int                 run_len;
    out_word_t          w;
    n_taken++;
    if (st) begin
      dec_phase    = DEC_FLAG;
      flag_idx     = '0;
      dec_count    = '0;
      dec_finished = 1'b0;
    end
    if (dec_finished || dec_count >= dec_length) begin
      dec_finished = 1'b1;
      return;
    end
    case (dec_phase)
      DEC_DATA: begin
        if (flag_bits[flag_idx]) begin
          emit_byte(b);
          advance_flag();
        end else begin
          tok_low   = b;
          dec_phase = DEC_HIGH;
        end
      end
      DEC_HIGH: begin
        field   = {b[3:0], tok_low};
        run_len = int'(b[7:4]) + 3;
        src     = wr_pos + field;
        for (int i = 0; i < run_len && !dec_finished; i++) begin
          emit_byte(hist[src]);
          src = src + 1'b1;
        end
        advance_flag();
      end
      default: begin
        flag_bits = b;
        flag_idx  = '0;
        dec_phase = DEC_DATA;
      end
    endcase
    // mark the closing byte of this word's run
    while (run_bytes.size() > 0) begin
      w      = run_bytes.pop_front();
      w.last = (run_bytes.size() == 0);
      exp_bytes.push_back(w);
    end
  endtask

  // offer one compressed byte, predict on acceptance, then maybe gap
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= st;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, st);
    if (tx_idle_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop valid, wait for all predicted bytes, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    dec_length  = v;
  endtask

  // well-formed flag groups with random content; restarts when breaks are on
  task automatic send_stream(input bit with_breaks, input int max_groups);
    logic [7:0]         flags;
    logic [7:0]         hi;
    logic [HIST_AW-1:0] field;
    bit                 start;
    int                 groups;
    start  = 1'b1;
    groups = 0;
    while ((groups == 0 || !dec_finished) && groups < max_groups) begin
      flags = 8'($urandom);
      send_byte(flags, start);
      start = 1'b0;
      groups++;
      for (int k = 0; k < 8 && !dec_finished && !start; k++) begin
        if (with_breaks && $urandom_range(0, 60) == 0) begin
          start = 1'b1;
        end else if (flags[k]) begin
          send_byte(8'($urandom), 1'b0);
        end else begin
          // mostly short distances into recent output, some anywhere
          if ($urandom_range(0, 9) < 6)
            field = HIST_AW'(HIST_DEPTH - int'($urandom_range(1, 40)));
          else
            field = HIST_AW'($urandom);
          hi = {4'($urandom), field[11:8]};
          send_byte(field[7:0], 1'b0);
          if (with_breaks && $urandom_range(0, 60) == 0) start = 1'b1;
          else send_byte(hi, 1'b0);
        end
      end
    end
  endtask

  // decode before any stream start, reading history never written since reset
  task automatic test_no_stream_start();
    write_length(24'd40);
    send_byte(8'h06, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
  endtask

  // a length lowered below the produced count ends the stream
  task automatic test_lowered_length();
    wait_idle();
    write_length(24'd20);
    send_byte(8'h55, 1'b0);
  endtask

  task automatic test_zero_length();
    wait_idle();
    write_length('0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hAA, 1'b0);
  endtask

  // longest overlapping copy cut short by the length, trailing byte ignored
  task automatic test_run_past_end();
    wait_idle();
    write_length(24'd5);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
  endtask

  task automatic test_max_length();
    wait_idle();
    write_length(24'hFF_FFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // hold the receiver off while the sender keeps offering words
  task automatic test_backpressure();
    wait_idle();
    write_length(24'd3000);
    rx_mode    <= RX_ALWAYS;
    tx_idle_on  = 1'b0;
    hold_req   <= hold_req + 1;
    send_stream(1'b0, 8);
  endtask

  task automatic test_random_streams();
    logic [CFG_W-1:0] len;
    int               pick;
    while (n_taken < ITEM_TARGET) begin
      wait_idle();
      pick = $urandom_range(0, 19);
      if (pick == 0)      len = '0;
      else if (pick < 3)  len = CFG_W'(1);
      else if (pick < 5)  len = CFG_W'($urandom_range(2, 4));
      else                len = CFG_W'($urandom_range(5, 150));
      write_length(len);
      rx_mode    <= rx_mode_t'($urandom_range(0, 2));
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        // raw noise with occasional restarts
        repeat (20) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end else begin
        send_stream(1'b1, 60);
      end
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    foreach (hist[i]) hist[i] = '0;
    wr_pos       = '0;
    flag_bits    = '0;
    flag_idx     = '0;
    dec_phase    = DEC_FLAG;
    tok_low      = '0;
    dec_count    = '0;
    dec_finished = 1'b0;
    dec_length   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_no_stream_start();
    test_lowered_length();
    test_zero_length();
    test_run_past_end();
    test_max_length();
    test_backpressure();
    test_random_streams();
    wait_idle();
    if (n_errors == 0 && exp_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: long hold on request, otherwise the selected stall pattern
  always @(posedge clk) begin
    rx_pat <= {rx_pat[9:0], rx_pat[10]};
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default:   out_tready <= rx_pat[10];
      endcase
    end
  end

  task automatic report_mismatch(input string name, input int want, input int got);
    n_errors++;
    // keep the log short when everything goes wrong
    if (n_errors <= MAX_REPORTS)
      $error("%s: expected %0h, got %0h", name, want, got);
  endtask

  // compare each output word with the oldest prediction
  always @(posedge clk) begin : check_out
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_bytes.size() == 0) begin
        report_mismatch("unexpected out_byte", -1, int'(out_tdata));
      end else begin
        want = exp_bytes.pop_front();
        if (out_tdata !== want.data)
          report_mismatch("out_byte", int'(want.data), int'(out_tdata));
        if (out_tlast !== want.last)
          report_mismatch("run_last", int'(want.last), int'(out_tlast));
        if (out_tuser[0] !== want.done)
          report_mismatch("stream_done", int'(want.done), int'(out_tuser[0]));
      end
    end
  end

  // end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
